>>> hdl/okeenc_pkg.sv
// shared types and constants for the ordered key element encoder
package okeenc_pkg;

  typedef enum logic [2:0] {
    OP_NULL      = 3'd0,
    OP_INTEGER   = 3'd1,
    OP_BOOL      = 3'd2,
    OP_STR_START = 3'd3,
    OP_STR_BYTE  = 3'd4,
    OP_STR_END   = 3'd5,
    OP_SEP       = 3'd6,
    OP_VARINT    = 3'd7
  } op_t;

  localparam logic [1:0] TEXT_STRING = 2'd1;
  localparam logic [1:0] UUID_STRING = 2'd2;

  localparam logic [7:0] TAG_NULL        = 8'd15;
  localparam logic [7:0] TAG_NEG_INTEGER = 8'd20;
  localparam logic [7:0] TAG_INTEGER     = 8'd21;
  localparam logic [7:0] TAG_BOOL        = 8'd30;
  localparam logic [7:0] TAG_BLOB        = 8'd40;
  localparam logic [7:0] TAG_TEXT        = 8'd50;
  localparam logic [7:0] TAG_UUID        = 8'd90;
  localparam logic [7:0] TAG_SEP         = 8'd102;
  localparam logic [7:0] ESC_BYTE        = 8'd1;
  localparam logic [7:0] ESC_ZERO        = 8'd1;
  localparam logic [7:0] ESC_ONE         = 8'd2;
  localparam logic [7:0] STR_TERM        = 8'd0;

  // varint range limits
  localparam logic [63:0] VAR_ONE_LIMIT  = 64'd240;
  localparam logic [63:0] VAR_TWO_MAX    = 64'd2287;
  localparam logic [63:0] VAR_THREE_MAX  = 64'd67823;
  localparam logic [10:0] VAR_TWO_BASE   = 11'd240;
  localparam logic [15:0] VAR_THREE_BASE = 16'd2288;
  localparam logic [7:0]  VAR_TWO_LEAD   = 8'd241;
  localparam logic [7:0]  VAR_THREE_LEAD = 8'hf9;
  // lead byte of the long forms is this plus the byte count (0xfa for 3 .. 0xff for 8)
  localparam logic [7:0]  VAR_LONG_BASE  = 8'hf7;

  localparam int QUEUE_DEPTH = 4;

  // one encoded element: up to two leading bytes, then up to eight payload bytes
  typedef struct packed {
    logic [1:0]  pre_cnt;
    logic [7:0]  pre0;
    logic [7:0]  pre1;
    logic [3:0]  pay_cnt;
    logic [63:0] pay;
  } desc_t;

endpackage

>>> hdl/okeenc_front.sv
// front end: accepts elements, classifies them and builds byte descriptors
module okeenc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           op,
  input  logic signed [63:0]   int_value,
  input  logic                 bool_value,
  input  logic [1:0]           string_kind,
  input  logic [7:0]           data_byte,
  input  logic                 closed,
  output logic                 push,
  output okeenc_pkg::desc_t    push_desc,
  input  logic                 queue_full
);
  import okeenc_pkg::*;

  logic        s1_valid;
  logic        s1_none;
  logic        s1_var;
  logic        s1_tag_en;
  logic [7:0]  s1_tag;
  desc_t       s1_fix;
  logic [63:0] s1_mag;

  logic        c_none;
  logic        c_var;
  logic        c_tag_en;
  logic [7:0]  c_tag;
  desc_t       c_fix;
  logic [63:0] c_mag;

  logic        s1_go;
  logic        in_fire;

  // classify the incoming element
  always_comb begin
    c_none   = 1'b0;
    c_var    = 1'b0;
    c_tag_en = 1'b0;
    c_tag    = TAG_INTEGER;
    c_mag    = int_value;
    c_fix    = '0;
    case (op_t'(op))
      OP_NULL: begin
        c_fix.pre_cnt = 2'd1;
        c_fix.pre0    = TAG_NULL;
      end
      OP_INTEGER: begin
        c_var    = 1'b1;
        c_tag_en = 1'b1;
        if (int_value[63]) begin
          c_tag = TAG_NEG_INTEGER;
          c_mag = 64'd0 - $unsigned(int_value);
        end
      end
      OP_BOOL: begin
        c_fix.pre_cnt = 2'd2;
        c_fix.pre0    = TAG_BOOL;
        c_fix.pre1    = {7'd0, bool_value};
      end
      OP_STR_START: begin
        c_fix.pre_cnt = 2'd1;
        if (string_kind == TEXT_STRING) begin
          c_fix.pre0 = TAG_TEXT;
        end else if (string_kind == UUID_STRING) begin
          c_fix.pre0 = TAG_UUID;
        end else begin
          c_fix.pre0 = TAG_BLOB;
        end
      end
      OP_STR_BYTE: begin
        if (data_byte == 8'd0) begin
          c_fix.pre_cnt = 2'd2;
          c_fix.pre0    = ESC_BYTE;
          c_fix.pre1    = ESC_ZERO;
        end else if (data_byte == 8'd1) begin
          c_fix.pre_cnt = 2'd2;
          c_fix.pre0    = ESC_BYTE;
          c_fix.pre1    = ESC_ONE;
        end else begin
          c_fix.pre_cnt = 2'd1;
          c_fix.pre0    = data_byte;
        end
      end
      OP_STR_END: begin
        if (closed || string_kind == UUID_STRING) begin
          c_fix.pre_cnt = 2'd1;
          c_fix.pre0    = STR_TERM;
        end else begin
          c_none = 1'b1;
        end
      end
      OP_SEP: begin
        c_fix.pre_cnt = 2'd1;
        c_fix.pre0    = TAG_SEP;
      end
      OP_VARINT: begin
        c_var = 1'b1;
      end
      default: begin
        c_none = 1'b1;
      end
    endcase
  end

  // varint form selection on the registered magnitude
  logic [3:0]  nb;
  logic [10:0] d_two;
  logic [15:0] d_three;
  logic        m_en;
  logic [7:0]  marker;
  logic [63:0] v_pay;
  logic [3:0]  v_cnt;
  desc_t       desc;

  always_comb begin
    nb = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (|s1_mag[i*8 +: 8]) begin
        nb = 4'(i + 1);
      end
    end
    d_two   = s1_mag[10:0] - VAR_TWO_BASE;
    d_three = s1_mag[15:0] - VAR_THREE_BASE;
    m_en    = 1'b0;
    marker  = VAR_THREE_LEAD;
    v_pay   = s1_mag;
    v_cnt   = 4'd1;
    if (s1_mag < VAR_ONE_LIMIT) begin
      v_cnt = 4'd1;
    end else if (s1_mag <= VAR_TWO_MAX) begin
      v_pay = {48'd0, 8'(VAR_TWO_LEAD + {5'd0, d_two[10:8]}), d_two[7:0]};
      v_cnt = 4'd2;
    end else if (s1_mag <= VAR_THREE_MAX) begin
      m_en  = 1'b1;
      v_pay = {48'd0, d_three};
      v_cnt = 4'd2;
    end else begin
      m_en   = 1'b1;
      marker = 8'(VAR_LONG_BASE + {4'd0, nb});
      v_cnt  = nb;
    end

    if (s1_var) begin
      desc.pay     = v_pay;
      desc.pay_cnt = v_cnt;
      if (s1_tag_en) begin
        desc.pre0    = s1_tag;
        desc.pre1    = marker;
        desc.pre_cnt = m_en ? 2'd2 : 2'd1;
      end else begin
        desc.pre0    = marker;
        desc.pre1    = marker;
        desc.pre_cnt = m_en ? 2'd1 : 2'd0;
      end
    end else begin
      desc = s1_fix;
    end
  end

  // an element with no output bytes leaves without a queue entry
  assign s1_go     = s1_valid && (s1_none || !queue_full);
  assign push      = s1_valid && !s1_none && !queue_full;
  assign push_desc = desc;
  assign in_ready  = !s1_valid || s1_go;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_none   <= c_none;
      s1_var    <= c_var;
      s1_tag_en <= c_tag_en;
      s1_tag    <= c_tag;
      s1_fix    <= c_fix;
      s1_mag    <= c_mag;
    end
  end

endmodule

>>> hdl/okeenc_fifo.sv
// small descriptor queue between front and back ends
module okeenc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             head_valid
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

>>> hdl/okeenc_back.sv
// back end: serializes descriptors into the output byte stream
module okeenc_back (
  input  logic              clk,
  input  logic              rst,
  input  okeenc_pkg::desc_t head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last
);
  import okeenc_pkg::*;

  logic [1:0]  pre_cnt;
  logic [7:0]  pre0;
  logic [7:0]  pre1;
  logic [3:0]  pay_cnt;
  logic [63:0] pay;

  logic        busy;
  logic        emit;
  logic        load;
  logic        is_last;
  logic [2:0]  pay_idx;
  logic [7:0]  cur_byte;

  assign busy    = (pre_cnt != 2'd0) || (pay_cnt != 4'd0);
  assign is_last = (4'({2'd0, pre_cnt} + pay_cnt) == 4'd1);
  assign pay_idx = 3'(pay_cnt - 4'd1);
  assign emit    = busy && (!out_valid || out_ready);
  // next descriptor comes in on the cycle the current one sends its last byte
  assign load    = head_valid && (!busy || (emit && is_last));
  assign pop     = load;

  always_comb begin
    if (pre_cnt != 2'd0) begin
      cur_byte = pre0;
    end else begin
      cur_byte = pay[{pay_idx, 3'd0} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_cnt <= 2'd0;
      pay_cnt <= 4'd0;
    end else if (load) begin
      pre_cnt <= head.pre_cnt;
      pay_cnt <= head.pay_cnt;
    end else if (emit) begin
      if (pre_cnt != 2'd0) begin
        pre_cnt <= pre_cnt - 2'd1;
      end else begin
        pay_cnt <= pay_cnt - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pre0 <= head.pre0;
      pre1 <= head.pre1;
      pay  <= head.pay;
    end else if (emit && pre_cnt != 2'd0) begin
      pre0 <= pre1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= cur_byte;
      last     <= is_last;
    end
  end

endmodule

>>> hdl/ordered_key_element_encoder_unit.sv
// top level of the ordered key element encoder
//
// Input channel (in_valid / in_ready) takes one key element or one piece of a
// string per transaction: op selects null, integer, bool, string start, string
// byte, string end, separator or bare varint; the other fields carry its data.
// Output channel (out_valid / out_ready) gives one byte of the key stream per
// transaction, with last set on the final byte an element produces.
// An element yields 1 to 10 bytes (integers: tag plus a 1 to 9 byte varint);
// an unclosed non-uuid string end yields none.
// The first byte of an element appears after it has passed the front-end
// stage register, the descriptor queue and the back-end registers. Throughput is
// one output byte per cycle while the receiver is ready, set by the single
// byte-serializing back end; inputs are taken every cycle while the
// descriptor queue (QUEUE_DEPTH entries) has room.
// Reset (rst, synchronous) empties the queue and the pipeline.
// When the receiver stalls, the output byte holds, the back end waits, the
// queue fills and then in_ready drops; no byte is lost or repeated.
module ordered_key_element_encoder_unit #(
  parameter int FIFO_DEPTH = okeenc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic signed [63:0] int_value,
  input  logic               bool_value,
  input  logic [1:0]         string_kind,
  input  logic [7:0]         data_byte,
  input  logic               closed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               last
);
  import okeenc_pkg::*;

  localparam int DW = $bits(desc_t);

  logic             push;
  desc_t            push_desc;
  logic             queue_full;
  logic             pop;
  logic [DW-1:0]    head_bits;
  logic             head_valid;

  okeenc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .int_value   (int_value),
    .bool_value  (bool_value),
    .string_kind (string_kind),
    .data_byte   (data_byte),
    .closed      (closed),
    .push        (push),
    .push_desc   (push_desc),
    .queue_full  (queue_full)
  );

  okeenc_fifo #(
    .WIDTH (DW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_desc),
    .full       (queue_full),
    .pop        (pop),
    .head       (head_bits),
    .head_valid (head_valid)
  );

  okeenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (desc_t'(head_bits)),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule
